FILE: rtl/core/qrmfd_pkg.sv
// Package for the quarter-rate mixer / FIR decimator.
// Holds widths, reset constants, the low-pass kernel and the datapath control types.
// No dependencies.
package qrmfd_pkg;

    localparam int TAP_COUNT_DEF  = 31;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int SAMPLE_W       = 16;
    localparam int MIX_W          = SAMPLE_W + 1;
    localparam int LEN_W          = 20;
    localparam int OUT_W          = 20;
    localparam int PHASE_W        = 2;
    localparam int KERNEL_LEN     = 31;
    localparam int OUT_MAX        = 524287;
    localparam int OUT_MIN        = -524288;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(180000);

    // Hamming-windowed low-pass, Q1.23
    localparam int KERNEL_Q23 [KERNEL_LEN] = '{
        7892, 15829, 24068, 26345, 10969, -31599, -97902, -163783,
        -186060, -115887, 80025, 399195, 794301, 1181485, 1464935, 1568983,
        1464935, 1181485, 794301, 399195, 80025, -115887, -186060, -163783,
        -97902, -31599, 10969, 26345, 24068, 15829, 7892
    };

    // Kernel tap rounded half up to Q1.(cw-1); taps past the kernel are zero
    function automatic logic signed [23:0] coef_round(input int k, input int cw);
        logic signed [24:0] c;
        int                 s;
        s = 24 - cw;
        if (k >= KERNEL_LEN) begin
            return '0;
        end
        c = 25'(KERNEL_Q23[k]);
        if (s > 0) begin
            c = (c + (25'sd1 <<< (s - 1))) >>> s;
        end
        return c[23:0];
    endfunction

    typedef struct packed {
        logic acc_clear;
        logic tap_valid;
        logic tap_live;
        logic finish;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
    } mac_status_t;

endpackage

FILE: rtl/core/qrmfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qrmfd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 31
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/qrmfd_mac.sv
// Shared multiply-accumulate unit: one tap per cycle, then round and saturate.
// Depends on qrmfd_pkg (kernel, control types).
module qrmfd_mac
    import qrmfd_pkg::*;
#(
    parameter int TAP_COUNT  = TAP_COUNT_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mac_ctrl_t                         ctrl,
    input  logic [$clog2(TAP_COUNT+1)-1:0]    tap_idx,
    input  logic signed [MIX_W-1:0]           tap_data,
    output mac_status_t                       status,
    output logic signed [OUT_W-1:0]           sample
);

    localparam int PROD_W = MIX_W + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 6;
    localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'(1) <<< (COEF_WIDTH - 4);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

    logic signed [23:0]           coef_full;
    logic signed [COEF_WIDTH-1:0] coef;
    logic signed [PROD_W-1:0]     prod_reg;
    logic                         v2_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [ACC_W-1:0]      rnd_reg;
    logic signed [ACC_W-1:0]      shifted;

    always_comb begin
        coef_full = coef_round(int'(tap_idx), COEF_WIDTH);
        coef      = coef_full[COEF_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= ctrl.tap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.tap_valid) begin
            prod_reg <= ctrl.tap_live ? PROD_W'(tap_data * coef) : '0;
        end
        if (ctrl.acc_clear) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.finish) begin
            rnd_reg <= acc_reg + BIAS;
        end
    end

    assign shifted = rnd_reg >>> (COEF_WIDTH - 3);

    always_comb begin
        priority if (shifted > SAT_HI) begin
            sample = OUT_W'(OUT_MAX);
        end else if (shifted < SAT_LO) begin
            sample = OUT_W'(OUT_MIN);
        end else begin
            sample = shifted[OUT_W-1:0];
        end
    end

    assign status.busy = v2_reg;

endmodule

FILE: rtl/core/quarter_rate_mixer_fir_decimator.sv
// In a capture, an input that gives no result is only written into the delay-line RAM;
// every fourth input also starts a filter run (one RAM read and one MAC per tap, pipeline
// drain, rounding) that puts its result in the output register. s_ready stays low until
// that load, which waits on m_ready, as the single shared MAC serves one run at a time.
// Reset (aresetn low, synchronous): idle, no capture, capture_length back to 180000.
// Arm clears the delay line through a fill count, not by sweeping the RAM.
module quarter_rate_mixer_fir_decimator
    import qrmfd_pkg::*;
#(
    parameter int TAP_COUNT  = TAP_COUNT_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_i_sample,
    input  logic signed [SAMPLE_W-1:0] s_q_sample,
    input  logic                       s_arm,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_W-1:0]    m_filtered_sample,
    output logic                       m_last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [LEN_W-1:0]           cfg_data
);

    localparam int AW = $clog2(TAP_COUNT);
    localparam int KW = $clog2(TAP_COUNT + 1);
    localparam logic [KW-1:0] TAPS    = KW'(TAP_COUNT);
    localparam logic [AW-1:0] LAST_AD = AW'(TAP_COUNT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_RND  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [PHASE_W-1:0] PH_I     = 2'd0;
    localparam logic [PHASE_W-1:0] PH_Q     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_NEG_I = 2'd2;
    localparam logic [PHASE_W-1:0] PH_NEG_Q = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [KW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic               active_reg, active_next;
    logic [LEN_W-1:0]   len_reg;
    logic [KW-1:0]      issue_reg, issue_next;
    logic [AW-1:0]      raddr_reg, raddr_next;
    logic               v1_reg, v1_next;
    logic [KW-1:0]      k1_reg, k1_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0] m_sample_reg;
    logic               m_last_reg;

    logic                     accept;
    logic                     issuing;
    logic                     load_out;
    logic                     done;
    logic [LEN_W-1:0]         count_plus;
    logic signed [MIX_W-1:0]  i_ext, q_ext, mixed;
    logic                     ram_we, ram_re;
    logic signed [MIX_W-1:0]  ram_rdata;
    mac_ctrl_t                mac_ctrl;
    mac_status_t              mac_status;
    logic signed [OUT_W-1:0]  mac_sample;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign issuing   = (state_reg == ST_MAC) && (issue_reg < TAPS);
    assign load_out  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign count_plus = count_reg + LEN_W'(1);
    assign done      = count_plus >= len_reg;

    assign i_ext = MIX_W'(s_i_sample);
    assign q_ext = MIX_W'(s_q_sample);

    always_comb begin
        unique case (s_arm ? PH_I : phase_reg)
            PH_I:     mixed = i_ext;
            PH_Q:     mixed = q_ext;
            PH_NEG_I: mixed = -i_ext;
            PH_NEG_Q: mixed = -q_ext;
            default:  mixed = i_ext;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        fill_next    = fill_reg;
        wp_next      = wp_reg;
        count_next   = count_reg;
        active_next  = active_reg;
        issue_next   = issue_reg;
        raddr_next   = raddr_reg;
        v1_next      = issuing;
        k1_next      = issue_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        mac_ctrl     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_arm) begin
                        phase_next  = '0;
                        fill_next   = '0;
                        count_next  = '0;
                        active_next = 1'b1;
                    end
                    if (s_arm || active_reg) begin
                        ram_we     = 1'b1;
                        wp_next    = (wp_reg == LAST_AD) ? '0 : wp_reg + AW'(1);
                        fill_next  = (s_arm || fill_reg == TAPS) ?
                                     (s_arm ? KW'(1) : TAPS) : fill_reg + KW'(1);
                        phase_next = (s_arm ? PH_I : phase_reg) + PHASE_W'(1);
                        if (phase_next == PH_I) begin
                            state_next        = ST_MAC;
                            issue_next        = '0;
                            raddr_next        = wp_reg;
                            mac_ctrl.acc_clear = 1'b1;
                        end
                    end
                end
            end
            ST_MAC: begin
                if (issuing) begin
                    issue_next = issue_reg + KW'(1);
                    raddr_next = (raddr_reg == '0) ? LAST_AD : raddr_reg - AW'(1);
                end else if (!v1_reg && !mac_status.busy) begin
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                mac_ctrl.finish = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    count_next   = count_plus;
                    if (done) begin
                        active_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        mac_ctrl.tap_valid = v1_reg;
        mac_ctrl.tap_live  = k1_reg < fill_reg;
    end

    assign ram_re = issuing;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            fill_reg    <= '0;
            wp_reg      <= '0;
            count_reg   <= '0;
            active_reg  <= 1'b0;
            len_reg     <= LEN_RESET;
            issue_reg   <= '0;
            raddr_reg   <= '0;
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            fill_reg    <= fill_next;
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            active_reg  <= active_next;
            issue_reg   <= issue_next;
            raddr_reg   <= raddr_next;
            v1_reg      <= v1_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k1_reg <= k1_next;
        if (load_out) begin
            m_sample_reg <= mac_sample;
            m_last_reg   <= done;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_filtered_sample = m_sample_reg;
    assign m_last            = m_last_reg;

    qrmfd_ram #(
        .WIDTH (MIX_W),
        .DEPTH (TAP_COUNT)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (mixed),
        .re    (ram_re),
        .raddr (raddr_reg),
        .rdata (ram_rdata)
    );

    qrmfd_mac #(
        .TAP_COUNT  (TAP_COUNT),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .tap_idx  (k1_reg),
        .tap_data (ram_rdata),
        .status   (mac_status),
        .sample   (mac_sample)
    );

`ifndef SYNTHESIS
    // filter only runs on a phase boundary
    a_phase_zero_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> phase_reg == PH_I)
        else $error("phase not aligned while filter busy");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= TAPS && issue_reg <= TAPS)
        else $error("fill or tap counter out of range");

    a_last_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && done |=> !active_reg)
        else $error("capture still active after last transfer");

    a_no_out_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready && state_reg != ST_OUT |=> m_valid_reg)
        else $error("pending result dropped");
`endif

endmodule
